// ===== hdl/ecg_pkg.sv =====
// Shared constants, control word type and microcode table for the equal column hash grouper.
package ecg_pkg;

	// default sizes
	localparam int MAX_COLS_DEF = 16;
	localparam int MAX_ROWS_DEF = 1024;

	// golden ratio multiplier of the column hash
	localparam logic [31:0] HASH_MUL = 32'h9e37_79b1;

	// stream and register port widths
	localparam int ELEM_W     = 32;
	localparam int OUT_DATA_W = 8;   // column_index(4) + group_number(3), padded to a byte
	localparam int OUT_USER_W = 2;   // last_in_group, none_found
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int ROWS_W     = 11;
	localparam int COLS_W     = 5;
	localparam int COLIDX_W   = 4;
	localparam int GRP_W      = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_ACC = 4'd0;   // load elements
	localparam logic [STEP_W-1:0] ST_RI  = 4'd1;   // read hash of column i
	localparam logic [STEP_W-1:0] ST_LR  = 4'd2;   // latch reference hash
	localparam logic [STEP_W-1:0] ST_RJ  = 4'd3;   // read hash of column j
	localparam logic [STEP_W-1:0] ST_CJ  = 4'd4;   // compare
	localparam logic [STEP_W-1:0] ST_CF  = 4'd5;   // group already open?
	localparam logic [STEP_W-1:0] ST_GS  = 4'd6;   // open group with column i
	localparam logic [STEP_W-1:0] ST_EM  = 4'd7;   // add member j
	localparam logic [STEP_W-1:0] ST_NJ  = 4'd8;   // next j
	localparam logic [STEP_W-1:0] ST_EI  = 4'd9;   // next i
	localparam logic [STEP_W-1:0] ST_FIN = 4'd10;  // final word, clear

	// jump conditions
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS = 3'd0;
	localparam logic [COND_W-1:0] C_NDONE  = 3'd1;
	localparam logic [COND_W-1:0] C_REP_I  = 3'd2;
	localparam logic [COND_W-1:0] C_J_END  = 3'd3;
	localparam logic [COND_W-1:0] C_NMATCH = 3'd4;
	localparam logic [COND_W-1:0] C_FOUND  = 3'd5;
	localparam logic [COND_W-1:0] C_NILAST = 3'd6;

	typedef struct packed {
		logic              in_rdy;    // take elements
		logic              rd_j;      // hash read address from j, else i
		logic              ld_ref;
		logic              j_init;
		logic              j_inc;
		logic              i_adv;     // next i, close group
		logic              p_from_i;  // open group: pending member := i
		logic              p_from_j;  // pending member := j
		logic              push;      // emit pending member
		logic              lig;
		logic              last;
		logic              fin;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] jmp;
	} ucw_t;

	function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
		ucw_t w;
		w = '0;
		case (step)
			ST_ACC: begin
				w.in_rdy = 1'b1; w.cond = C_NDONE; w.jmp = ST_ACC;
			end
			ST_RI: begin
				w.cond = C_REP_I; w.jmp = ST_EI;
			end
			ST_LR: begin
				w.ld_ref = 1'b1; w.j_init = 1'b1; w.cond = C_ALWAYS; w.jmp = ST_RJ;
			end
			ST_RJ: begin
				w.rd_j = 1'b1; w.cond = C_J_END; w.jmp = ST_EI;
			end
			ST_CJ: begin
				w.cond = C_NMATCH; w.jmp = ST_NJ;
			end
			ST_CF: begin
				w.cond = C_FOUND; w.jmp = ST_EM;
			end
			ST_GS: begin
				w.push = 1'b1; w.lig = 1'b1; w.p_from_i = 1'b1;
				w.cond = C_ALWAYS; w.jmp = ST_EM;
			end
			ST_EM: begin
				w.push = 1'b1; w.p_from_j = 1'b1; w.j_inc = 1'b1;
				w.cond = C_ALWAYS; w.jmp = ST_RJ;
			end
			ST_NJ: begin
				w.j_inc = 1'b1; w.cond = C_ALWAYS; w.jmp = ST_RJ;
			end
			ST_EI: begin
				w.i_adv = 1'b1; w.cond = C_NILAST; w.jmp = ST_RI;
			end
			ST_FIN: begin
				w.push = 1'b1; w.lig = 1'b1; w.last = 1'b1; w.fin = 1'b1;
				w.cond = C_ALWAYS; w.jmp = ST_ACC;
			end
			default: begin
				w.cond = C_ALWAYS; w.jmp = ST_ACC;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/ecg_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module ecg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/equal_column_hash_grouper_core.sv =====
// Top level: per-column hash accumulation and microcoded grouping of equal columns.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | tdata: element_value (32, signed)
//  m_*     | out | m_tvalid / m_tready  | tdata: column_index, group_number; tuser:
//          |     |                      | last_in_group, none_found; tlast: last_result
//  cfg_*   | in  | cfg_valid/cfg_ready  | cfg_index 0 rows_in_use, 1 cols_in_use
//
//  Load: one element word per clock in the load step. Multiply (registered), then a hash
//  RAM read-modify-write; one forwarding register covers back-to-back hits on a column.
//  After the last element the two-stage pipe drains, then the sequencer runs: per
//  unreported column i it latches its hash and compares each later column j, opening a
//  group on the first match and adding each match; reported columns are skipped; one
//  closing step ends the pass. It holds on an emitting step during an m_tready stall.
//  Reset: counters, valid bits and sequencer cleared at once; no clearing pass.
//  Hash RAM entries carry valid bits cleared at the end of every matrix.
module equal_column_hash_grouper_core #(
	parameter int MAX_COLS = ecg_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = ecg_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// element stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ecg_pkg::ELEM_W-1:0]       s_tdata,   // [31:0] element_value
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ecg_pkg::OUT_DATA_W-1:0]   m_tdata,   // [3:0] column_index, [6:4] group_number, [7] zero
	output logic [ecg_pkg::OUT_USER_W-1:0]   m_tuser,   // [0] last_in_group, [1] none_found
	output logic                             m_tlast,   // last_result
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ecg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW  = $clog2(MAX_COLS);      // column address
	localparam int CNW = $clog2(MAX_COLS + 1);  // column count
	localparam int RW  = $clog2(MAX_ROWS + 1);  // row count

	// ---------------- registers ----------------
	logic [ecg_pkg::ROWS_W-1:0] rows_q;
	logic [ecg_pkg::COLS_W-1:0] cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ecg_pkg::ROWS_W'(1);
			cols_q <= ecg_pkg::COLS_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				ecg_pkg::REG_ROWS: rows_q <= cfg_data;
				ecg_pkg::REG_COLS: cols_q <= cfg_data[ecg_pkg::COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes: zero reads as one, oversize clamps to the maximum
	logic [CNW-1:0] n_cols;
	logic [RW-1:0]  n_rows;

	always_comb begin
		if (cols_q == '0) begin
			n_cols = CNW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			n_cols = CNW'(MAX_COLS);
		end else begin
			n_cols = CNW'(cols_q);
		end
		if (rows_q == '0) begin
			n_rows = RW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			n_rows = RW'(MAX_ROWS);
		end else begin
			n_rows = RW'(rows_q);
		end
	end

	// ---------------- sequencer ----------------
	logic [ecg_pkg::STEP_W-1:0] step_q;
	ecg_pkg::ucw_t              cw;
	logic                       out_free;
	logic                       go;
	logic                       cond_true;

	assign cw       = ecg_pkg::ucode(step_q);
	assign out_free = !m_tvalid || m_tready;
	assign go       = !cw.push || out_free;

	// ---------------- load pipe ----------------
	logic [CNW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic           end_q;      // last element taken
	logic           take;
	logic [CNW-1:0] col_inc;
	logic [RW-1:0]  row_inc;

	logic signed [63:0] prod_w;
	logic [63:0]        prod_s1, prod_s2;
	logic [AW-1:0]      col_s1, col_s2;
	logic               vld_s1, vld_s2;
	logic [63:0]        fwd_sum_q;
	logic [AW-1:0]      fwd_col_q;
	logic               fwd_vld_q;

	assign s_tready = cw.in_rdy && !end_q;
	assign take     = s_tvalid && s_tready;
	assign col_inc  = col_q + CNW'(1);
	assign row_inc  = row_q + RW'(1);
	assign prod_w   = $signed(s_tdata) * $signed({1'b0, ecg_pkg::HASH_MUL});

	// hash store
	logic [AW-1:0]       raddr;
	logic [63:0]         rdata;
	logic [63:0]         rd_val;
	logic [63:0]         acc_base;
	logic [63:0]         acc_sum;
	logic [MAX_COLS-1:0] hv_q;    // entry written this matrix
	logic                rv_q;

	// grouping datapath
	logic [CNW-1:0]      i_q, j_q;
	logic [AW-1:0]       i_a, j_a;
	logic [63:0]         ref_q;
	logic                found_q;
	logic [ecg_pkg::GRP_W-1:0] grp_q;
	logic                p_valid_q;
	logic [AW-1:0]       p_col_q;
	logic [ecg_pkg::GRP_W-1:0] p_grp_q;
	logic [MAX_COLS-1:0] rep_q;   // already reported
	logic [AW+3:0]       p_col_ext;
	logic                none;

	assign i_a = i_q[AW-1:0];
	assign j_a = j_q[AW-1:0];

	assign raddr    = cw.in_rdy ? col_s1 : (cw.rd_j ? j_a : i_a);
	assign rd_val   = rv_q ? rdata : 64'd0;
	assign acc_base = (fwd_vld_q && fwd_col_q == col_s2) ? fwd_sum_q : rd_val;
	assign acc_sum  = acc_base + prod_s2;

	ecg_ram #(
		.WIDTH(64),
		.DEPTH(MAX_COLS)
	) u_hash (
		.clk  (clk),
		.we   (vld_s2),
		.waddr(col_s2),
		.wdata(acc_sum),
		.raddr(raddr),
		.rdata(rdata)
	);

	// payload stages
	always_ff @(posedge clk) begin
		prod_s1   <= prod_w;
		col_s1    <= col_q[AW-1:0];
		prod_s2   <= prod_s1;
		col_s2    <= col_s1;
		fwd_sum_q <= acc_sum;
		fwd_col_q <= col_s2;
		if (cw.ld_ref) begin
			ref_q <= rd_val;
		end
	end

	// jump condition
	always_comb begin
		case (cw.cond)
			ecg_pkg::C_ALWAYS: cond_true = 1'b1;
			ecg_pkg::C_NDONE:  cond_true = !(end_q && !vld_s1 && !vld_s2);
			ecg_pkg::C_REP_I:  cond_true = rep_q[i_a];
			ecg_pkg::C_J_END:  cond_true = (j_q >= n_cols);
			ecg_pkg::C_NMATCH: cond_true = (rd_val != ref_q);
			ecg_pkg::C_FOUND:  cond_true = found_q;
			ecg_pkg::C_NILAST: cond_true = ((i_q + CNW'(1)) < n_cols);
			default:           cond_true = 1'b1;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ecg_pkg::ST_ACC;
			col_q     <= '0;
			row_q     <= '0;
			end_q     <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			fwd_vld_q <= 1'b0;
			hv_q      <= '0;
			rv_q      <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			found_q   <= 1'b0;
			grp_q     <= '0;
			p_valid_q <= 1'b0;
			rep_q     <= '0;
		end else begin
			vld_s1    <= take;
			vld_s2    <= vld_s1;
			fwd_vld_q <= vld_s2;
			rv_q      <= hv_q[raddr];
			if (vld_s2) begin
				hv_q[col_s2] <= 1'b1;
			end

			// row / column position; matrix ends on the last row's last column
			if (take) begin
				if (col_inc >= n_cols) begin
					col_q <= '0;
					if (row_inc >= n_rows) begin
						row_q <= '0;
						end_q <= 1'b1;
					end else begin
						row_q <= row_inc;
					end
				end else begin
					col_q <= col_inc;
				end
			end

			if (go) begin
				step_q <= cond_true ? cw.jmp : step_q + ecg_pkg::STEP_W'(1);
				if (cw.j_init) begin
					j_q <= i_q + CNW'(1);
				end
				if (cw.j_inc) begin
					j_q <= j_q + CNW'(1);
				end
				if (cw.p_from_i) begin
					p_valid_q   <= 1'b1;
					found_q     <= 1'b1;
					rep_q[i_a]  <= 1'b1;
				end
				if (cw.p_from_j) begin
					rep_q[j_a]  <= 1'b1;
				end
				if (cw.i_adv) begin
					i_q     <= i_q + CNW'(1);
					found_q <= 1'b0;
					if (found_q) begin
						grp_q <= grp_q + ecg_pkg::GRP_W'(1);
					end
				end
				if (cw.fin) begin
					i_q       <= '0;
					end_q     <= 1'b0;
					found_q   <= 1'b0;
					grp_q     <= '0;
					p_valid_q <= 1'b0;
					rep_q     <= '0;
					hv_q      <= '0;
				end
			end
		end
	end

	// pending member: held back until the next emitting step so its flags are known when it leaves
	always_ff @(posedge clk) begin
		if (go && cw.p_from_i) begin
			p_col_q <= i_a;
			p_grp_q <= grp_q;
		end
		if (go && cw.p_from_j) begin
			p_col_q <= j_a;
			p_grp_q <= grp_q;
		end
	end

	// ---------------- output register ----------------
	logic                        m_valid_q;
	logic [ecg_pkg::COLIDX_W-1:0] o_col_q;
	logic [ecg_pkg::GRP_W-1:0]    o_grp_q;
	logic                        o_lig_q, o_last_q, o_none_q;
	logic                        emit;

	assign none      = cw.fin && !p_valid_q;
	assign emit      = go && cw.push && (p_valid_q || cw.fin);
	assign p_col_ext = {4'b0, p_col_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_col_q  <= none ? '0 : p_col_ext[ecg_pkg::COLIDX_W-1:0];
			o_grp_q  <= none ? '0 : p_grp_q;
			o_lig_q  <= none ? 1'b0 : cw.lig;
			o_last_q <= cw.last;
			o_none_q <= none;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, o_grp_q, o_col_q};
	assign m_tuser  = {o_none_q, o_lig_q};
	assign m_tlast  = o_last_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the equal column hash grouper: random matrices, stalls, size changes.
module tb_top;

	localparam int          IDLE_PCT    = 21;
	localparam int          DRAIN_CYC   = 16;     // pipe drain and clear after the final word
	localparam int          STALL_LIMIT = 5000;   // watchdog limit, above the longest grouping pass
	localparam int          COLS_CAP    = 16;
	localparam int          ROWS_CAP    = 1024;
	localparam logic [63:0] GOLDEN      = 64'h0000_0000_9e37_79b1;

	typedef struct packed {
		logic [3:0] col;
		logic [2:0] grp;
		logic       lig;
		logic       last;
		logic       nf;
	} group_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [10:0] cfg_data  = '0;

	// element words waiting for the driver, results still owed by the block
	logic [31:0] elem_q [$];
	group_word_t due_words [$];

	// shadow of the block: sizes, position in the matrix, column hashes
	logic [10:0] rows_reg = 11'd1;
	logic [4:0]  cols_reg = 5'd1;
	int unsigned row_pos  = 0;
	int unsigned col_pos  = 0;
	logic [63:0] col_hash [COLS_CAP];

	// stimulus scratch
	logic [31:0] mat  [ROWS_CAP][COLS_CAP];
	logic [31:0] tmpl [ROWS_CAP][COLS_CAP];

	int  n_sent = 0, n_taken = 0, n_results = 0, n_matrices = 0, n_groups = 0;
	int  n_none = 0, errors = 0, stall_cnt = 0;
	bit  in_took = 1'b0, out_took = 1'b0, calm = 1'b0;

	equal_column_hash_grouper_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned rows_used(input logic [10:0] r);
		if (r == 0) return 1;
		if (r > ROWS_CAP) return ROWS_CAP;
		return r;
	endfunction

	function automatic int unsigned cols_used(input logic [4:0] c);
		if (c == 0) return 1;
		if (c > COLS_CAP) return COLS_CAP;
		return c;
	endfunction

	// Fold one element into its column; on the matrix's last element queue the group report.
	task automatic absorb_element(input logic [31:0] e);
		logic        partner [COLS_CAP];
		logic        done    [COLS_CAP];
		group_word_t batch [$];
		group_word_t w;
		int unsigned n, last_j;
		logic [2:0]  grp;
		if (col_pos >= COLS_CAP) col_pos = 0;
		col_hash[col_pos] = col_hash[col_pos] + {{32{e[31]}}, e} * GOLDEN;
		col_pos++;
		if (col_pos >= cols_used(cols_reg)) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= rows_used(rows_reg)) begin
				n = cols_used(cols_reg);
				for (int i = 0; i < COLS_CAP; i++) begin
					partner[i] = 1'b0;
					done[i]    = 1'b0;
				end
				for (int i = 0; i < n; i++)
					for (int j = i + 1; j < n; j++)
						if (col_hash[i] == col_hash[j]) begin
							partner[i] = 1'b1;
							partner[j] = 1'b1;
						end
				grp = '0;
				for (int i = 0; i < n; i++) begin
					if (partner[i] && !done[i]) begin
						last_j = i;
						for (int j = i; j < n; j++)
							if (col_hash[j] == col_hash[i]) last_j = j;
						for (int j = i; j < n; j++) begin
							if (col_hash[j] == col_hash[i]) begin
								done[j] = 1'b1;
								w       = '0;
								w.col   = 4'(j);
								w.grp   = grp;
								w.lig   = (j == last_j);
								batch.push_back(w);
							end
						end
						grp = grp + 3'd1;
						n_groups++;
					end
				end
				if (batch.size() == 0) begin
					w    = '0;
					w.nf = 1'b1;
					batch.push_back(w);
					n_none++;
				end
				w      = batch[batch.size()-1];
				w.last = 1'b1;
				batch[batch.size()-1] = w;
				foreach (batch[k]) due_words.push_back(batch[k]);
				for (int i = 0; i < COLS_CAP; i++) col_hash[i] = '0;
				row_pos = 0;
				n_matrices++;
			end
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endfunction

	// Fresh input word only once the last has gone; random gaps and m_tready stalls unless calm.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || in_took) begin
				if (elem_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_tdata  <= elem_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Sample both streams on the rising edge; results are checked before the element of
	// the same edge is folded in, so a stray result cannot match a fresh expectation.
	always @(posedge clk) begin : monitor
		group_word_t exp_w;
		in_took  = arst_n && s_tvalid && s_tready;
		out_took = arst_n && m_tvalid && m_tready;
		if (out_took) begin
			n_results++;
			if (due_words.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, tdata %h tuser %b tlast %b",
					$realtime, m_tdata, m_tuser, m_tlast);
			end else begin
				exp_w = due_words.pop_front();
				check_field("column_index", exp_w.col, m_tdata[3:0]);
				check_field("group_number", exp_w.grp, m_tdata[6:4]);
				check_field("last_in_group", exp_w.lig, m_tuser[0]);
				check_field("none_found", exp_w.nf, m_tuser[1]);
				check_field("last_result", exp_w.last, m_tlast);
			end
		end
		if (in_took) begin
			absorb_element(s_tdata);
			n_taken++;
		end
		if (arst_n) begin
			if (in_took || out_took || (cfg_valid && cfg_ready)) stall_cnt = 0;
			else stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: watchdog, no word moved for %0d cycles", $realtime, stall_cnt);
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [31:0] e);
		elem_q.push_back(e);
		n_sent++;
	endtask

	// Wait until every element is taken and every result is in, then let the pipe drain.
	task automatic settle();
		do @(negedge clk); while (n_taken != n_sent || due_words.size() != 0);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == ecg_pkg::REG_ROWS) rows_reg = val;
		else if (idx == ecg_pkg::REG_COLS) cols_reg = val[4:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_sizes(input logic [10:0] rows, input logic [10:0] cols);
		if ($urandom_range(0, 1)) begin
			write_reg(ecg_pkg::REG_ROWS, rows);
			write_reg(ecg_pkg::REG_COLS, cols);
		end else begin
			write_reg(ecg_pkg::REG_COLS, cols);
			write_reg(ecg_pkg::REG_ROWS, rows);
		end
	endtask

	function automatic logic [31:0] pick_element(input int mode);
		case (mode)
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hffff_ffff;
					3: return 32'h8000_0000;
					default: return 32'h7fff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// One whole matrix at the current sizes. Half the time columns copied from a few templates,
	// often with the rows shuffled, so that equal sums come from unequal columns too.
	task automatic send_matrix();
		int unsigned nr, nc, ntmpl, sel, k;
		int          mode;
		logic [31:0] tmp;
		nr    = rows_used(rows_reg);
		nc    = cols_used(cols_reg);
		k     = $urandom_range(0, 9);
		mode  = (k < 2) ? 0 : ((k < 5) ? 2 : 1);
		ntmpl = $urandom_range(1, nc);
		for (int c = 0; c < nc; c++)
			for (int r = 0; r < nr; r++)
				tmpl[r][c] = pick_element(mode);
		for (int c = 0; c < nc; c++) begin
			sel = $urandom_range(0, ntmpl - 1);
			for (int r = 0; r < nr; r++)
				mat[r][c] = (mode == 1) ? tmpl[r][sel] : pick_element(mode);
			if (mode == 1 && $urandom_range(0, 1))
				for (int r = nr - 1; r > 0; r--) begin
					k          = $urandom_range(0, r);
					tmp        = mat[r][c];
					mat[r][c]  = mat[k][c];
					mat[k][c]  = tmp;
				end
		end
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				send_word(mat[r][c]);
	endtask

	task automatic random_phase();
		logic [10:0]  rows, cols;
		int unsigned  k, total;
		k = $urandom_range(0, 99);
		if (k < 15) cols = {6'($urandom), 5'($urandom_range(0, 1))};
		else if (k < 30) cols = {6'($urandom), 5'($urandom_range(17, 31))};
		else cols = {6'($urandom), 5'($urandom_range(2, 16))};
		k = $urandom_range(0, 99);
		if (k < 10) rows = 11'd0;
		else if (k < 20 && cols_used(cols[4:0]) <= 4) rows = 11'($urandom_range(7, 20));
		else rows = 11'($urandom_range(1, 6));
		settle();
		write_sizes(rows, cols);
		total = rows_used(rows_reg) * cols_used(cols_reg);
		if (total > 1 && $urandom_range(0, 5) == 0) begin
			// resize part way through a matrix, then feed until it closes
			k = $urandom_range(1, total - 1);
			repeat (k) send_word($urandom);
			settle();
			write_sizes(11'($urandom_range(0, 4)), {6'($urandom), 5'($urandom)});
			while (row_pos != 0 || col_pos != 0) begin
				send_word($urandom);
				do @(negedge clk); while (n_taken != n_sent);
			end
		end else begin
			send_matrix();
		end
	endtask

	initial begin
		for (int i = 0; i < COLS_CAP; i++) col_hash[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// single column at reset sizes: nothing can pair up
		send_word(32'h8000_0000);
		settle();
		// zero sizes read as one
		write_sizes(11'd0, 11'd0);
		send_word(32'h7fff_ffff);
		settle();
		// two identical columns of the most negative value
		write_sizes(11'd1, 11'd2);
		send_word(32'h8000_0000);
		send_word(32'h8000_0000);
		settle();
		// two groups, each pair equal only by its sum
		write_sizes(11'd2, 11'd4);
		send_word(32'hffff_ffff);
		send_word(32'h7fff_ffff);
		send_word(32'd5);
		send_word(32'h8000_0000);
		send_word(32'h7fff_ffff);
		send_word(32'hffff_ffff);
		send_word(32'h8000_0000);
		send_word(32'd5);
		settle();
		// column count cut to two while the row pointer already stands at column two
		write_sizes(11'd2, 11'd3);
		send_word(32'd5);
		send_word(32'hffff_fffb);
		settle();
		write_reg(ecg_pkg::REG_COLS, 11'd2);
		send_word(32'd7);
		send_word(32'hffff_fffb);
		send_word(32'd5);

		while (n_sent < 240) begin
			calm = (n_sent >= 80 && n_sent < 150);
			random_phase();
		end
		calm = 1'b0;

		// oversized rows clamp to the maximum, so twenty rows do not close the matrix;
		// upper data bits of the column write ignored; a row count of one then closes it
		settle();
		write_sizes(11'd2047, 11'h020);
		repeat (20) send_word($urandom);
		settle();
		write_reg(ecg_pkg::REG_ROWS, 11'd0);
		send_word($urandom);
		// oversized column count clamps to sixteen
		settle();
		write_sizes(11'd2, 11'h7ff);
		send_matrix();
		settle();

		$display("Covered %0d matrices from %0d element words: %0d result words,", n_matrices,
			n_sent, n_results);
		$display("%0d groups reported, %0d matrices with no equal columns.", n_groups, n_none);
		if (errors == 0 && due_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
